### rtl/tlin_pkg.sv
// ----------------------------------------------------------------------------
// Thermocouple table linearizer package
// Shared widths, register and status codes, and the structs passed between
// the sequencer, the breakpoint memory and the serial divider.
// ----------------------------------------------------------------------------
package tlin_pkg;

	// Default table depth.
	localparam int TABLE_DEPTH_DEF = 64;

	// Field widths.
	localparam int IDX_W   = 6;
	localparam int CODE_W  = 16;
	localparam int DEG_W   = 16;
	localparam int EU_W    = 7;
	localparam int HOT_W   = 21;
	localparam int COLD_W  = 14;
	localparam int TOTAL_W = 22;
	localparam int STAT_W  = 2;

	// Serial divider: 32-bit magnitude scaled by 32, 16-bit divisor.
	localparam int DIV_NUM_W = 37;
	localparam int DIV_DEN_W = 16;
	localparam int DIV_Q_W   = 21;

	// Register reset values.
	localparam logic [EU_W-1:0]          ENTRIES_RST  = 7'd64;
	localparam logic signed [DEG_W-1:0]  MAX_TEMP_RST = 16'sd1372;
	localparam logic signed [DEG_W-1:0]  MIN_TEMP_RST = -16'sd270;

	// Register indexes (word addresses).
	localparam logic [1:0] REG_ENTRIES  = 2'd0;
	localparam logic [1:0] REG_MAX_TEMP = 2'd1;
	localparam logic [1:0] REG_MIN_TEMP = 2'd2;

	// Word kinds.
	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_CONVERT = 1'b1;

	// Range status codes.
	localparam logic [STAT_W-1:0] RS_WITHIN = 2'd0;
	localparam logic [STAT_W-1:0] RS_HIGH   = 2'd1;
	localparam logic [STAT_W-1:0] RS_LOW    = 2'd2;

	// One breakpoint as held in the table memory.
	typedef struct packed {
		logic signed [CODE_W-1:0] code;
		logic signed [DEG_W-1:0]  degrees;
	} entry_t;

	// Divider request and response.
	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_Q_W-1:0] quot;
	} div_rsp_t;

	// One result word.
	typedef struct packed {
		logic signed [STAT_W-1:0]  status;
		logic signed [COLD_W-1:0]  cold;
		logic signed [HOT_W-1:0]   hot;
		logic signed [TOTAL_W-1:0] total;
	} res_t;

endpackage

### rtl/tlin_ram.sv
// ----------------------------------------------------------------------------
// Breakpoint table memory
// Synchronous memory with one write port and one registered read port.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module tlin_ram
	import tlin_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	localparam int AW = $clog2(TABLE_DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data
);

	entry_t mem [TABLE_DEPTH];
	entry_t rd_data_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/tlin_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle. A start pulse loads
// the operands; done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module tlin_div
	import tlin_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CW = $clog2(DIV_NUM_W + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;

	logic [DIV_DEN_W:0]   shifted;
	logic [DIV_DEN_W:0]   diff;
	logic                 fits;

	// Trial subtraction of the divisor from the partial remainder.
	always_comb begin
		shifted = {rem_q, num_q[DIV_NUM_W-1]};
		diff    = shifted - {1'b0, den_q};
		fits    = (shifted >= {1'b0, den_q});
	end

	// Iteration: the numerator register fills with quotient bits from the right.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else begin
			// Done follows the last iteration for one cycle.
			done_q <= busy_q && !req.start && (cnt_q == CW'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_NUM_W);
				num_q  <= req.num;
				rem_q  <= '0;
				den_q  <= req.den;
			end else if (busy_q) begin
				num_q <= {num_q[DIV_NUM_W-2:0], fits};
				rem_q <= fits ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = num_q[DIV_Q_W-1:0];

endmodule

### rtl/tlin_ctrl.sv
// ----------------------------------------------------------------------------
// Linearizer sequencer
// Writes breakpoints, walks the table for a reading, multiplies the offsets,
// drives the serial divider and holds the result in an output register.
// ----------------------------------------------------------------------------
module tlin_ctrl
	import tlin_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	localparam int AW = $clog2(TABLE_DEPTH)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     in_mode,
	input  logic [IDX_W-1:0]         in_index,
	input  entry_t                   in_entry,
	input  logic signed [CODE_W-1:0] in_hot,
	input  logic signed [CODE_W-1:0] in_cold,
	input  logic [AW-1:0]            last_idx,
	input  logic signed [DEG_W-1:0]  max_temp,
	input  logic signed [DEG_W-1:0]  min_temp,
	output logic                     wr_en,
	output logic [AW-1:0]            wr_addr,
	output entry_t                   wr_data,
	output logic [AW-1:0]            rd_addr,
	input  entry_t                   rd_data,
	output div_req_t                 div_req,
	input  div_rsp_t                 div_rsp,
	output logic                     out_valid,
	input  logic                     out_ready,
	output res_t                     out_res
);

	localparam int NW = ((IDX_W > AW) ? IDX_W : AW) + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LAST,
		S_FIRST,
		S_WALK,
		S_MUL,
		S_DIV,
		S_WAIT,
		S_FIN
	} state_t;

	state_t                     state_q;
	logic signed [CODE_W-1:0]   h_q;
	logic signed [COLD_W-1:0]   cold_q;
	logic [AW-1:0]              last_idx_q;
	logic [AW-1:0]              idx_q;
	entry_t                     last_q;
	entry_t                     prev_q;
	logic signed [DEG_W-1:0]    t1_q;
	logic signed [DEG_W:0]      dt_q;
	logic [CODE_W-1:0]          dh_q;
	logic [DIV_DEN_W-1:0]       den_q;
	logic signed [2*DEG_W+1:0]  prod_q;
	logic                       neg_q;
	logic signed [HOT_W-1:0]    hot_q;
	logic [STAT_W-1:0]          status_q;
	logic                       out_valid_q;
	res_t                       out_res_q;

	logic                       accept;
	logic                       idx_ok;
	logic [2*DEG_W+1:0]         mag;
	logic [DIV_Q_W-1:0]         quot_signed;

	// Handshake and table writes.
	always_comb begin
		in_ready = (state_q == S_IDLE);
		accept   = in_valid && in_ready;
		idx_ok   = (NW'(in_index) < NW'(TABLE_DEPTH));
		wr_en    = accept && (in_mode == MODE_LOAD) && idx_ok;
		wr_addr  = AW'(in_index);
		wr_data  = in_entry;
	end

	// Read address: last breakpoint, then the first, then one step ahead of the walk.
	always_comb begin
		case (state_q)
			S_IDLE:  rd_addr = last_idx;
			S_LAST:  rd_addr = '0;
			S_FIRST: rd_addr = AW'(1);
			S_WALK:  rd_addr = idx_q + 1'b1;
			default: rd_addr = '0;
		endcase
	end

	// Divider operands: magnitude of the product, scaled by 32.
	always_comb begin
		mag             = prod_q[2*DEG_W+1] ? (~prod_q + 1'b1) : prod_q;
		div_req.start   = (state_q == S_DIV);
		div_req.num     = {mag[DIV_NUM_W-6:0], 5'b0};
		div_req.den     = den_q;
		quot_signed     = neg_q ? (~div_rsp.quot + 1'b1) : div_rsp.quot;
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			h_q         <= '0;
			cold_q      <= '0;
			last_idx_q  <= '0;
			idx_q       <= '0;
			last_q      <= '0;
			prev_q      <= '0;
			t1_q        <= '0;
			dt_q        <= '0;
			dh_q        <= '0;
			den_q       <= '0;
			prod_q      <= '0;
			neg_q       <= 1'b0;
			hot_q       <= '0;
			status_q    <= RS_WITHIN;
			out_valid_q <= 1'b0;
			out_res_q   <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && (in_mode == MODE_CONVERT)) begin
						h_q        <= in_hot;
						cold_q     <= in_cold[CODE_W-1:2];
						last_idx_q <= last_idx;
						state_q    <= S_LAST;
					end
				end
				S_LAST: begin
					last_q  <= rd_data;
					state_q <= S_FIRST;
				end
				S_FIRST: begin
					// Clamp outside the table, otherwise start the interval walk.
					if (h_q > last_q.code) begin
						hot_q    <= {max_temp, 5'b0};
						status_q <= RS_HIGH;
						state_q  <= S_FIN;
					end else if (h_q < rd_data.code) begin
						hot_q    <= {min_temp, 5'b0};
						status_q <= RS_LOW;
						state_q  <= S_FIN;
					end else begin
						prev_q  <= rd_data;
						idx_q   <= AW'(1);
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if ((h_q >= prev_q.code) && (h_q < rd_data.code)) begin
						t1_q     <= prev_q.degrees;
						dt_q     <= (DEG_W+1)'(rd_data.degrees) - (DEG_W+1)'(prev_q.degrees);
						dh_q     <= CODE_W'(h_q - prev_q.code);
						den_q    <= DIV_DEN_W'(rd_data.code - prev_q.code);
						status_q <= RS_WITHIN;
						state_q  <= S_MUL;
					end else if (idx_q == last_idx_q) begin
						// A code equal to the last breakpoint takes its temperature.
						if (h_q == last_q.code) begin
							hot_q    <= {last_q.degrees, 5'b0};
							status_q <= RS_WITHIN;
						end else begin
							hot_q    <= {min_temp, 5'b0};
							status_q <= RS_LOW;
						end
						state_q <= S_FIN;
					end else begin
						prev_q <= rd_data;
						idx_q  <= idx_q + 1'b1;
					end
				end
				S_MUL: begin
					prod_q  <= $signed({1'b0, dh_q}) * dt_q;
					state_q <= S_DIV;
				end
				S_DIV: begin
					neg_q   <= prod_q[2*DEG_W+1];
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_rsp.done) begin
						hot_q   <= $signed({t1_q, 5'b0}) + $signed(quot_signed);
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_res_q.total  <= TOTAL_W'(hot_q) + TOTAL_W'(cold_q);
						out_res_q.hot    <= hot_q;
						out_res_q.cold   <= cold_q;
						out_res_q.status <= status_q;
						out_valid_q      <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

endmodule

### rtl/thermocouple_table_linearizer.sv
// A load word is written at the edge that accepts it; one load per cycle while
// no reading is in progress. A clamped reading goes through S_LAST, S_FIRST and
// S_FIN to its result word; an interpolated one also walks the table to its
// interval, then goes through S_MUL, S_DIV and the 37-step serial divider.
// One reading at a time; reset clears control and registers, not the table.
// ----------------------------------------------------------------------------
// Thermocouple table linearizer
// Breakpoint table with linear interpolation of the hot junction code,
// cold junction scaling and an APB register port.
// ----------------------------------------------------------------------------
module thermocouple_table_linearizer
	import tlin_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input words
	input  logic        s_tvalid,
	output logic        s_tready,
	// entry_index[5:0], entry_code[21:6], entry_degrees[37:22], raw_hot[53:38],
	// cj_raw[69:54], zero[71:70]
	input  logic [71:0] s_tdata,
	// mode[0]
	input  logic        s_tuser,
	// Result words
	output logic        m_tvalid,
	input  logic        m_tready,
	// total_temp[21:0], hot_temp[42:22], cold_temp[56:43], range_status[58:57],
	// zero[63:59]
	output logic [63:0] m_tdata
);

	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int NW2 = (EU_W > AW + 1) ? EU_W : AW + 1;

	logic [EU_W-1:0]          entries_q;
	logic signed [DEG_W-1:0]  max_temp_q;
	logic signed [DEG_W-1:0]  min_temp_q;
	logic                     cfg_wr;
	logic [NW2-1:0]           eu;
	logic [NW2-1:0]           n_used;
	logic [AW-1:0]            last_idx;
	entry_t                   in_entry;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	entry_t                   wr_data;
	logic [AW-1:0]            rd_addr;
	entry_t                   rd_data;
	div_req_t                 div_req;
	div_rsp_t                 div_rsp;
	res_t                     res;

	// Register writes.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q  <= ENTRIES_RST;
			max_temp_q <= MAX_TEMP_RST;
			min_temp_q <= MIN_TEMP_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_ENTRIES:  entries_q  <= pwdata[EU_W-1:0];
				REG_MAX_TEMP: max_temp_q <= pwdata[DEG_W-1:0];
				REG_MIN_TEMP: min_temp_q <= pwdata[DEG_W-1:0];
				default: ;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		case (paddr[3:2])
			REG_ENTRIES:  prdata = 32'(entries_q);
			REG_MAX_TEMP: prdata = {16'b0, max_temp_q};
			REG_MIN_TEMP: prdata = {16'b0, min_temp_q};
			default:      prdata = '0;
		endcase
	end

	// Number of breakpoints in use, held between two and the table depth.
	always_comb begin
		eu = NW2'(entries_q);
		if (eu < NW2'(2)) begin
			n_used = NW2'(2);
		end else if (eu > NW2'(TABLE_DEPTH)) begin
			n_used = NW2'(TABLE_DEPTH);
		end else begin
			n_used = eu;
		end
		last_idx = AW'(n_used - 1'b1);
	end

	assign in_entry.code    = s_tdata[21:6];
	assign in_entry.degrees = s_tdata[37:22];

	tlin_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (s_tuser),
		.in_index  (s_tdata[5:0]),
		.in_entry  (in_entry),
		.in_hot    (s_tdata[53:38]),
		.in_cold   (s_tdata[69:54]),
		.last_idx  (last_idx),
		.max_temp  (max_temp_q),
		.min_temp  (min_temp_q),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	tlin_ram #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	tlin_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Result word packing.
	assign m_tdata = {5'b0, res.status, res.cold, res.hot, res.total};

`ifndef NO_ASSERTIONS
	// A reading occupies the sequencer, so the next word waits.
	a_convert_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == MODE_CONVERT)) |=> !s_tready)
		else $error("input accepted while a reading is in progress");

	// The total is always the sum of the hot and cold parts.
	a_total_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.total == (TOTAL_W'(res.hot) + TOTAL_W'(res.cold))))
		else $error("total does not equal hot plus cold");

	// A high clamp returns the configured maximum.
	a_high_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (res.status == RS_HIGH)) |-> (res.hot == {max_temp_q, 5'b0}))
		else $error("high clamp does not match the maximum temperature");
`endif

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// Thermocouple table linearizer testbench
// Drives breakpoint loads and readings into the stream port, programs the
// registers over the APB port while the block is idle, and checks every
// result word against a typed value or a predictor of the table walk and interpolation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import tlin_pkg::*;

	localparam int BP_DEPTH         = TABLE_DEPTH_DEF;
	localparam int DRAIN_CYCLES     = 150;
	localparam int WORDS_PER_PHASE  = 88;
	localparam int PHASES           = 9;

	// One input word, as the fields of the stream item.
	typedef struct packed {
		logic                     mode;
		logic [IDX_W-1:0]         idx;
		logic signed [CODE_W-1:0] code;
		logic signed [DEG_W-1:0]  deg;
		logic signed [CODE_W-1:0] raw_hot;
		logic signed [CODE_W-1:0] cj_raw;
	} word_in_t;

	// One result word, as the fields of the stream item.
	typedef struct packed {
		logic signed [TOTAL_W-1:0] total;
		logic signed [HOT_W-1:0]   hot;
		logic signed [COLD_W-1:0]  cold;
		logic [STAT_W-1:0]         status;
	} temp_word_t;

	// A directed row: the word, and its expected result where typed in.
	typedef struct packed {
		word_in_t   word;
		logic       typed;
		temp_word_t want;
	} stim_row_t;

	// One register setting for a random phase; rnd replaces the temperatures.
	typedef struct packed {
		logic [EU_W-1:0]         entries;
		logic signed [DEG_W-1:0] max_t;
		logic signed [DEG_W-1:0] min_t;
		logic                    rnd;
	} setting_t;

	// Directed words, run with two breakpoints in use and the reset temperatures.
	// Columns: mode, index, code, degrees, hot code, cold code; typed; expected
	// total, hot, cold and status.
	localparam stim_row_t DIRECTED_WORDS [24] = '{
		// Full-scale table from the most negative to the most positive code.
		'{'{MODE_LOAD, 6'd0, -16'sd32768, -16'sd32768, 16'sd0, 16'sd0}, 1'b0, '0},
		'{'{MODE_LOAD, 6'd1, 16'sd32767, 16'sd32767, 16'sd0, 16'sd0}, 1'b0, '0},
		// Code on the first breakpoint; 21'sh100000 is the most negative hot value.
		'{'{MODE_CONVERT, 6'd0, 16'sd0, 16'sd0, -16'sd32768, 16'sd0}, 1'b1,
			'{-22'sd1048576, 21'sh100000, 14'sd0, RS_WITHIN}},
		// Code on the last breakpoint, largest cold word.
		'{'{MODE_CONVERT, 6'd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd32767}, 1'b1,
			'{22'sd1056735, 21'sd1048544, 14'sd8191, RS_WITHIN}},
		'{'{MODE_CONVERT, 6'd0, 16'sd0, 16'sd0, 16'sd0, -16'sd32768}, 1'b0, '0},
		'{'{MODE_CONVERT, 6'd0, 16'sd0, 16'sd0, -16'sd1, -16'sd1}, 1'b0, '0},
		'{'{MODE_CONVERT, 6'd0, 16'sd0, 16'sd0, 16'sd21845, 16'sd16384}, 1'b0, '0},
		// Narrow table from code 100 to 200, 0 to 100 degrees.
		'{'{MODE_LOAD, 6'd0, 16'sd100, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
		'{'{MODE_LOAD, 6'd1, 16'sd200, 16'sd100, 16'sd0, 16'sd0}, 1'b0, '0},
		// Just below and just above the table.
		'{'{MODE_CONVERT, 6'd0, 16'sd0, 16'sd0, 16'sd99, 16'sd4}, 1'b1,
			'{-22'sd8639, -21'sd8640, 14'sd1, RS_LOW}},
		'{'{MODE_CONVERT, 6'd0, 16'sd0, 16'sd0, 16'sd201, 16'sd0}, 1'b1,
			'{22'sd43904, 21'sd43904, 14'sd0, RS_HIGH}},
		// Code extremes; 14'sh2000 is the most negative cold value.
		'{'{MODE_CONVERT, 6'd0, 16'sd0, 16'sd0, -16'sd32768, -16'sd32768}, 1'b1,
			'{-22'sd16832, -21'sd8640, 14'sh2000, RS_LOW}},
		'{'{MODE_CONVERT, 6'd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd32767}, 1'b1,
			'{22'sd52095, 21'sd43904, 14'sd8191, RS_HIGH}},
		'{'{MODE_CONVERT, 6'd0, 16'sd0, 16'sd0, 16'sd150, 16'sd3}, 1'b0, '0},
		// Equal to the last breakpoint, and a negative cold word that rounds down.
		'{'{MODE_CONVERT, 6'd0, 16'sd0, 16'sd0, 16'sd200, -16'sd4}, 1'b1,
			'{22'sd3199, 21'sd3200, -14'sd1, RS_WITHIN}},
		'{'{MODE_CONVERT, 6'd0, 16'sd0, 16'sd0, 16'sd100, -16'sd5}, 1'b1,
			'{-22'sd2, 21'sd0, -14'sd2, RS_WITHIN}},
		// Falling slope: the quotient is truncated toward zero.
		'{'{MODE_LOAD, 6'd1, 16'sd200, -16'sd7, 16'sd0, 16'sd0}, 1'b0, '0},
		'{'{MODE_CONVERT, 6'd0, 16'sd0, 16'sd0, 16'sd101, 16'sd0}, 1'b0, '0},
		'{'{MODE_CONVERT, 6'd0, 16'sd0, 16'sd0, 16'sd199, 16'sd0}, 1'b0, '0},
		// Two breakpoints on the same code.
		'{'{MODE_LOAD, 6'd0, 16'sd200, 16'sd5, 16'sd0, 16'sd0}, 1'b0, '0},
		'{'{MODE_CONVERT, 6'd0, 16'sd0, 16'sd0, 16'sd200, 16'sd0}, 1'b0, '0},
		// Table that is not ascending.
		'{'{MODE_LOAD, 6'd0, 16'sd300, 16'sd5, 16'sd0, 16'sd0}, 1'b0, '0},
		'{'{MODE_CONVERT, 6'd0, 16'sd0, 16'sd0, 16'sd250, 16'sd0}, 1'b0, '0},
		'{'{MODE_CONVERT, 6'd0, 16'sd0, 16'sd0, 16'sd200, 16'sd0}, 1'b0, '0}
	};

	// Register settings of the random phases, extremes of every register among them.
	localparam setting_t REG_PLAN [PHASES] = '{
		'{7'd0,   16'sd32767,  -16'sd32768, 1'b0},
		'{7'd64,  -16'sd32768, 16'sd32767,  1'b0},
		'{7'd5,   16'sd1372,   -16'sd270,   1'b1},
		'{7'd127, 16'sd0,      16'sd0,      1'b1},
		'{7'd2,   16'sd500,    -16'sd500,   1'b0},
		'{7'd17,  16'sd0,      16'sd0,      1'b1},
		'{7'd1,   16'sd0,      16'sd0,      1'b1},
		'{7'd64,  16'sd32767,  -16'sd32768, 1'b0},
		'{7'd9,   16'sd0,      16'sd0,      1'b1}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	// entry_index[5:0], entry_code[21:6], entry_degrees[37:22], raw_hot[53:38],
	// cj_raw[69:54], zero[71:70]
	logic [71:0] s_tdata;
	// mode[0]
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// total_temp[21:0], hot_temp[42:22], cold_temp[56:43], range_status[58:57],
	// zero[63:59]
	logic [63:0] m_tdata;

	// Predictor state: breakpoint table and register copies.
	logic signed [CODE_W-1:0] bp_code [BP_DEPTH];
	logic signed [DEG_W-1:0]  bp_deg [BP_DEPTH];
	logic [EU_W-1:0]          cfg_entries = ENTRIES_RST;
	logic signed [DEG_W-1:0]  cfg_max = MAX_TEMP_RST;
	logic signed [DEG_W-1:0]  cfg_min = MIN_TEMP_RST;

	// Stimulus copy of the table, used to aim readings at its intervals.
	int                       plan_code [BP_DEPTH];
	logic signed [DEG_W-1:0]  plan_deg [BP_DEPTH];

	temp_word_t pending_temps [$];
	int send_idle_pct = 31;
	int recv_idle_pct = 87;
	int mismatches = 0;
	int words_sent = 0;
	int loads_sent = 0;
	int readings_checked = 0;
	int n_within = 0;
	int n_high = 0;
	int n_low = 0;

	thermocouple_table_linearizer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Clock with a period of 2 ns.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Expected result of one reading from the current table and registers.
	function automatic temp_word_t linearize(logic signed [CODE_W-1:0] hot_code,
			logic signed [CODE_W-1:0] cold_code);
		temp_word_t r;
		longint h, a1, a2, t1, t2, hot, cold;
		int n;
		bit found;
		n = int'(cfg_entries);
		if (n < 2) n = 2;
		if (n > BP_DEPTH) n = BP_DEPTH;
		h = hot_code;
		cold = cold_code >>> 2;
		hot = 0;
		found = 1'b0;
		r.status = RS_WITHIN;
		if (h > longint'(bp_code[n-1])) begin
			hot = longint'(cfg_max) * 32;
			r.status = RS_HIGH;
		end else if (h < longint'(bp_code[0])) begin
			hot = longint'(cfg_min) * 32;
			r.status = RS_LOW;
		end else begin
			// Walk the intervals from the bottom; the first that holds the code wins.
			for (int i = 0; i + 1 < n && !found; i++) begin
				a1 = bp_code[i];
				a2 = bp_code[i+1];
				if (h >= a1 && h < a2) begin
					t1 = bp_deg[i];
					t2 = bp_deg[i+1];
					hot = t1 * 32 + (h - a1) * (t2 - t1) * 32 / (a2 - a1);
					found = 1'b1;
				end
			end
			if (!found) begin
				if (h == longint'(bp_code[n-1])) begin
					hot = longint'(bp_deg[n-1]) * 32;
				end else begin
					hot = longint'(cfg_min) * 32;
					r.status = RS_LOW;
				end
			end
		end
		r.hot = hot[HOT_W-1:0];
		r.cold = cold[COLD_W-1:0];
		hot = hot + cold;
		r.total = hot[TOTAL_W-1:0];
		return r;
	endfunction

	function automatic word_in_t random_word();
		word_in_t w;
		w.mode = MODE_CONVERT;
		w.idx = IDX_W'($urandom);
		w.code = CODE_W'($urandom);
		w.deg = DEG_W'($urandom);
		w.raw_hot = CODE_W'($urandom);
		w.cj_raw = CODE_W'($urandom);
		return w;
	endfunction

	// APB write: setup cycle, then access cycle; the register takes it at that edge.
	task automatic write_reg(input logic [1:0] reg_idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (reg_idx)
			REG_ENTRIES:  cfg_entries = value[EU_W-1:0];
			REG_MAX_TEMP: cfg_max = value[DEG_W-1:0];
			REG_MIN_TEMP: cfg_min = value[DEG_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Offer one word, idling first at the sender's rate, and update the
	// predictor at the edge that accepts it.
	task automatic send_word(input word_in_t w, input logic typed, input temp_word_t want);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= w.mode;
		s_tdata <= {2'b00, w.cj_raw, w.raw_hot, w.deg, w.code, w.idx};
		do @(posedge clk); while (!s_tready);
		words_sent++;
		if (w.mode == MODE_LOAD) begin
			bp_code[w.idx] = w.code;
			bp_deg[w.idx] = w.deg;
			loads_sent++;
		end else begin
			pending_temps.push_back(typed ? want : linearize(w.raw_hot, w.cj_raw));
		end
	endtask

	task automatic idle_input();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// Wait for every expected result, then let the block settle.
	task automatic drain(input int extra);
		while (pending_temps.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10) $display("MISMATCH at %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got)
			note_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
	endtask

	// The receiver stalls at its idle rate.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Compare each accepted result word with the oldest expectation.
	always @(posedge clk) begin : result_check
		temp_word_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.total = m_tdata[21:0];
			got.hot = m_tdata[42:22];
			got.cold = m_tdata[56:43];
			got.status = m_tdata[58:57];
			if (pending_temps.size() == 0) begin
				note_mismatch($sformatf("result word with none expected, total %0d",
					got.total));
			end else begin
				want = pending_temps.pop_front();
				readings_checked++;
				check_field("total_temp", want.total, got.total);
				check_field("hot_temp", want.hot, got.hot);
				check_field("cold_temp", want.cold, got.cold);
				check_field("range_status", want.status, got.status);
				case (want.status)
					RS_HIGH: n_high++;
					RS_LOW:  n_low++;
					default: n_within++;
				endcase
			end
		end
	end

	// Stimulus: directed words, then random phases, one register setting each.
	initial begin : stimulus
		int n, k, r, lo, hi, hot_i, maxstep, conv_count, phase_words;
		word_in_t w;
		setting_t cfg;
		logic signed [DEG_W-1:0] v_max, v_min;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_LOAD;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(REG_ENTRIES, 32'd2);
		foreach (DIRECTED_WORDS[i])
			send_word(DIRECTED_WORDS[i].word, DIRECTED_WORDS[i].typed,
				DIRECTED_WORDS[i].want);

		for (int p = 0; p < PHASES; p++) begin
			// Sender-light, then receiver-light, then no idling at all.
			send_idle_pct = (p / 3 == 0) ? 31 : (p / 3 == 1) ? 87 : 0;
			recv_idle_pct = (p / 3 == 0) ? 87 : (p / 3 == 1) ? 31 : 0;
			idle_input();
			drain(DRAIN_CYCLES);
			cfg = REG_PLAN[p];
			v_max = cfg.rnd ? DEG_W'($urandom) : cfg.max_t;
			v_min = cfg.rnd ? DEG_W'($urandom) : cfg.min_t;
			write_reg(REG_ENTRIES, {25'd0, cfg.entries});
			write_reg(REG_MAX_TEMP, {16'h0000, v_max});
			write_reg(REG_MIN_TEMP, {16'h0000, v_min});
			n = int'(cfg.entries);
			if (n < 2) n = 2;
			if (n > BP_DEPTH) n = BP_DEPTH;

			phase_words = 0;
			while (phase_words < WORDS_PER_PHASE) begin
				// Now and then hold off until every reading has come back.
				if ($urandom_range(0, 3) == 0) begin
					idle_input();
					drain(0);
				end
				// Fresh ascending table with random step sizes; one in eight is spoilt.
				maxstep = $urandom_range(1, 65535 / (n - 1));
				plan_code[0] = -32768 + int'($urandom_range(0, 65535 - (n - 1) * maxstep));
				for (k = 1; k < n; k++)
					plan_code[k] = plan_code[k-1] + int'($urandom_range(1, maxstep));
				for (k = 0; k < n; k++)
					plan_deg[k] = DEG_W'($urandom);
				if ($urandom_range(0, 7) == 0) begin
					k = $urandom_range(1, n - 1);
					plan_code[k] = $urandom_range(0, 1) ? plan_code[k-1] :
						$urandom_range(0, 65535) - 32768;
				end
				for (k = 0; k < n; k++) begin
					w = random_word();
					w.mode = MODE_LOAD;
					w.idx = IDX_W'(k);
					w.code = CODE_W'(plan_code[k]);
					w.deg = plan_deg[k];
					send_word(w, 1'b0, '0);
				end
				phase_words += n;

				// Readings aimed mostly inside the intervals, with stray loads mixed in.
				conv_count = $urandom_range(8, 30);
				repeat (conv_count) begin
					w = random_word();
					if ($urandom_range(0, 19) == 0) begin
						w.mode = MODE_LOAD;
						if (int'(w.idx) < n) begin
							plan_code[w.idx] = int'(w.code);
							plan_deg[w.idx] = w.deg;
						end
					end else begin
						r = $urandom_range(0, 9);
						if (r < 6) begin
							k = $urandom_range(0, n - 2);
							lo = plan_code[k];
							hi = plan_code[k+1];
							hot_i = (hi > lo) ? lo + int'($urandom_range(0, hi - lo)) : lo;
						end else if (r == 6) begin
							hot_i = plan_code[$urandom_range(0, n - 1)];
						end else begin
							hot_i = $urandom_range(0, 65535) - 32768;
						end
						w.raw_hot = CODE_W'(hot_i);
					end
					send_word(w, 1'b0, '0);
				end
				phase_words += conv_count;
			end
		end

		idle_input();
		drain(DRAIN_CYCLES);
		$display("Sent %0d words (%0d breakpoint loads) under %0d register settings.",
			words_sent, loads_sent, PHASES + 1);
		$display("Checked %0d readings: %0d interpolated, %0d high, %0d low; %0d mismatches.",
			readings_checked, n_within, n_high, n_low, mismatches);
		if (mismatches == 0 && pending_temps.size() == 0) begin
			$display("thermocouple_table_linearizer regression: pass");
		end else begin
			$display("thermocouple_table_linearizer regression: fail");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin : watchdog
		#4_000_000;
		$display("Timed out with %0d results outstanding.", pending_temps.size());
		$display("thermocouple_table_linearizer regression: fail");
		$finish;
	end

endmodule

### filelist.f
rtl/tlin_pkg.sv
rtl/tlin_ram.sv
rtl/tlin_div.sv
rtl/tlin_ctrl.sv
rtl/thermocouple_table_linearizer.sv
dv/tb_top.sv
